[hw/rtl/i2cbm_pkg.sv]
// i2cbm_pkg: shared types and constants for the I2C bus monitor.
// Used by i2cbm_glitch_filter and i2c_bus_monitor_core; no dependencies.
package i2cbm_pkg;

    // Event codes reported on the result channel
    typedef enum logic [1:0] {
        EV_START   = 2'd0,
        EV_RESTART = 2'd1,
        EV_BYTE    = 2'd2,
        EV_STOP    = 2'd3
    } t_event_kind;

    // Configuration register indexes
    typedef enum logic {
        CFG_ENABLE       = 1'b0,
        CFG_GLITCH_TICKS = 1'b1
    } t_cfg_index;

    localparam int unsigned CountW   = 8;
    localparam int unsigned BitIdxW  = 4;
    localparam logic [BitIdxW-1:0] BitsPerByte = 4'd8;

endpackage

[hw/rtl/i2c_bus_monitor_core.sv]
// i2c_bus_monitor_core: top level of the passive I2C bus monitor.
// Each result is registered in the output register, or in the skid entry while an earlier result is held.
// Throughput: one line sample per cycle while the skid entry is empty; a two-entry output stage
// (register plus skid) keeps the input open while one result waits.
// Reset (synchronous, active low): lines idle high, no transfer, config cleared (disabled).
// Depends on i2cbm_pkg and i2cbm_glitch_filter.
module i2c_bus_monitor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // line sample channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_scl_level,
    input  logic        i_sda_level,
    // event channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_data_byte,
    output logic        o_is_address,
    output logic        o_acked,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int unsigned BW = i2cbm_pkg::BitIdxW;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       is_address;
        logic       acked;
    } t_result;

    // configuration
    logic                         r_enable;
    logic [i2cbm_pkg::CountW-1:0] r_glitch_ticks;

    // decoder state
    logic          r_in_transfer, n_in_transfer;
    logic          r_expect_addr, n_expect_addr;
    logic [BW-1:0] r_bit_index,   n_bit_index;
    logic [7:0]    r_shift_byte,  n_shift_byte;

    // output stage
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid, n_res;
    logic    n_res_valid;

    logic accept, step, clear, out_take;
    logic old_scl, new_scl, old_sda, new_sda;

    assign accept   = i_in_valid && !o_in_stall;
    assign step     = accept && r_enable;
    assign clear    = accept && !r_enable;
    assign out_take = r_out_valid && !i_out_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b0;
            r_glitch_ticks <= '0;
        end else if (i_cfg_we) begin
            case (i2cbm_pkg::t_cfg_index'(i_cfg_index))
                i2cbm_pkg::CFG_ENABLE:       r_enable       <= i_cfg_data[0];
                i2cbm_pkg::CFG_GLITCH_TICKS: r_glitch_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Line filters
    i2cbm_glitch_filter u_scl_filter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_clear        (clear),
        .i_raw          (i_scl_level),
        .i_glitch_ticks (r_glitch_ticks),
        .o_level        (old_scl),
        .o_level_next   (new_scl)
    );

    i2cbm_glitch_filter u_sda_filter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_clear        (clear),
        .i_raw          (i_sda_level),
        .i_glitch_ticks (r_glitch_ticks),
        .o_level        (old_sda),
        .o_level_next   (new_sda)
    );

    // Protocol decode: SDA edge first against old SCL, then SCL rising edge
    always_comb begin
        n_in_transfer = r_in_transfer;
        n_expect_addr = r_expect_addr;
        n_bit_index   = r_bit_index;
        n_shift_byte  = r_shift_byte;
        n_res_valid   = 1'b0;
        n_res         = '0;
        if (old_scl && (new_sda != old_sda) && !new_sda) begin
            n_res_valid   = 1'b1;
            n_res.kind    = r_in_transfer ? i2cbm_pkg::EV_RESTART : i2cbm_pkg::EV_START;
            n_in_transfer = 1'b1;
            n_expect_addr = 1'b1;
            n_bit_index   = '0;
            n_shift_byte  = '0;
        end else if (old_scl && (new_sda != old_sda) && r_in_transfer) begin
            n_res_valid   = 1'b1;
            n_res.kind    = i2cbm_pkg::EV_STOP;
            n_in_transfer = 1'b0;
            n_bit_index   = '0;
            n_shift_byte  = '0;
        end else if (!old_scl && new_scl && r_in_transfer) begin
            if (r_bit_index < i2cbm_pkg::BitsPerByte) begin
                n_shift_byte = {r_shift_byte[6:0], new_sda};
                n_bit_index  = r_bit_index + BW'(1);
            end else begin
                // ninth clock: ack bit
                n_res_valid      = 1'b1;
                n_res.kind       = i2cbm_pkg::EV_BYTE;
                n_res.data_byte  = r_shift_byte;
                n_res.is_address = r_expect_addr;
                n_res.acked      = !new_sda;
                n_expect_addr    = 1'b0;
                n_bit_index      = '0;
                n_shift_byte     = '0;
            end
        end
    end

    // Decoder state; a disabled step returns everything to idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_in_transfer <= 1'b0;
            r_expect_addr <= 1'b1;
            r_bit_index   <= '0;
            r_shift_byte  <= '0;
        end else if (step) begin
            r_in_transfer <= n_in_transfer;
            r_expect_addr <= n_expect_addr;
            r_bit_index   <= n_bit_index;
            r_shift_byte  <= n_shift_byte;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= step && n_res_valid;
            end else begin
                r_out_valid  <= step && n_res_valid;
            end
        end else if (step && n_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end else if (step && n_res_valid) begin
            r_skid <= n_res;
        end
    end

    assign o_in_stall   = r_skid_valid;
    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_out.kind;
    assign o_data_byte  = r_out.data_byte;
    assign o_is_address = r_out.is_address;
    assign o_acked      = r_out.acked;

`ifndef SYNTHESIS
    // skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output entry");

    // bit counter never passes the ack position
    a_bit_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= i2cbm_pkg::BitsPerByte)
        else $error("bit index out of range");

    // no bits counted outside a transfer
    a_idle_no_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_transfer |-> (r_bit_index == '0))
        else $error("bit index nonzero while idle");

    // a disabled step aborts any transfer
    a_disable_aborts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear |=> !r_in_transfer)
        else $error("transfer survived disabled step");

    // a stalled result is not dropped
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");
`endif

endmodule

[hw/rtl/i2cbm_glitch_filter.sv]
// i2cbm_glitch_filter: per-line debounce for one sampled I2C line.
// Holds the filtered level and stability count; uses i2cbm_pkg.
module i2cbm_glitch_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic                             i_clear,
    input  logic                             i_raw,
    input  logic [i2cbm_pkg::CountW-1:0]     i_glitch_ticks,
    output logic                             o_level,
    output logic                             o_level_next
);

    localparam int unsigned CW = i2cbm_pkg::CountW;

    logic                          r_level;
    logic                          n_level;
    logic [i2cbm_pkg::CountW-1:0]  r_count;
    logic [i2cbm_pkg::CountW-1:0]  n_count;

    // Accept a new level once it has persisted past the threshold
    always_comb begin
        n_level = r_level;
        n_count = r_count;
        if (i_raw == r_level) begin
            n_count = '0;
        end else if (r_count >= i_glitch_ticks) begin
            n_level = i_raw;
            n_count = '0;
        end else begin
            n_count = r_count + CW'(1);
        end
    end

    // Idle level is high; clearing returns to that
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_level <= 1'b1;
            r_count <= '0;
        end else if (i_step) begin
            r_level <= n_level;
            r_count <= n_count;
        end
    end

    assign o_level      = r_level;
    assign o_level_next = n_level;

endmodule
